FILE: rtl/core/smfg_pkg.sv
package smfg_pkg;

    localparam int unsigned NumRows = 8;
    localparam int unsigned NumCols = 12;

    localparam logic [2:0] MODE_BOOT      = 3'd0;
    localparam logic [2:0] MODE_NORMAL    = 3'd1;
    localparam logic [2:0] MODE_COUNTDOWN = 3'd2;
    localparam logic [2:0] MODE_AP_READY  = 3'd3;
    localparam logic [2:0] MODE_UPLOADING = 3'd4;
    localparam logic [2:0] MODE_APPLYING  = 3'd5;
    localparam logic [2:0] MODE_ERROR     = 3'd6;
    localparam logic [2:0] MODE_BLANK     = 3'd7;

    // x / 100 == (x * MUL_DIV100) >> 37 and x / 500 == (x * MUL_DIV500) >> 37 for 32-bit x
    localparam logic [31:0] MUL_DIV100 = 32'h51EB_851F;
    localparam logic [31:0] MUL_DIV500 = 32'h1062_4DD3;
    localparam int unsigned DivShift = 37;

    // code / 10 == (code * MUL_DIV10) >> 11 for 8-bit code
    localparam logic [7:0] MUL_DIV10 = 8'd205;

    localparam logic [NumCols-1:0] STATUS_DOT = 12'h800;

    typedef logic [NumRows-1:0][NumCols-1:0] t_frame;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  error_code;
        logic [4:0]  health_mask;
        logic [31:0] time_ms;
    } t_req;

    // one row of a 3x5 digit, leftmost glyph pixel moved to the lowest bit
    function automatic logic [2:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
        logic [4:0][2:0] g;
        logic [2:0]      b;
        case (digit)
            4'd0: g = 15'b111_101_101_101_111;
            4'd1: g = 15'b010_110_010_010_111;
            4'd2: g = 15'b111_001_111_100_111;
            4'd3: g = 15'b111_001_111_001_111;
            4'd4: g = 15'b101_101_111_001_001;
            4'd5: g = 15'b111_100_111_001_111;
            4'd6: g = 15'b111_100_111_101_111;
            4'd7: g = 15'b111_001_001_001_001;
            4'd8: g = 15'b111_101_111_101_111;
            4'd9: g = 15'b111_101_111_001_111;
            default: g = '0;
        endcase
        if (row <= 3'd4) begin
            b = g[3'd4 - row];
        end else begin
            b = '0;
        end
        return {b[0], b[1], b[2]};
    endfunction

endpackage

FILE: rtl/core/smfg_render.sv
module smfg_render (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  smfg_pkg::t_req        i_req,
    output logic                  o_valid,
    output smfg_pkg::t_frame      o_frame
);

    // phase stage: time divides and digit split
    logic        r_s2_valid;
    logic [2:0]  r_s2_mode;
    logic [4:0]  r_s2_health;
    logic [2:0]  r_s2_fast;
    logic        r_s2_slow;
    logic [4:0]  r_s2_tens;
    logic [3:0]  r_s2_ones;

    logic [63:0] n_p100;
    logic [63:0] n_p500;
    logic [15:0] n_p10;
    logic [4:0]  n_tens;
    logic [7:0]  n_tens_x10;
    logic [7:0]  n_ones;

    always_comb begin
        n_p100     = 64'(i_req.time_ms) * 64'(smfg_pkg::MUL_DIV100);
        n_p500     = 64'(i_req.time_ms) * 64'(smfg_pkg::MUL_DIV500);
        n_p10      = 16'(i_req.error_code) * 16'(smfg_pkg::MUL_DIV10);
        n_tens     = n_p10[15:11];
        n_tens_x10 = 8'(n_tens) * 8'd10;
        n_ones     = i_req.error_code - n_tens_x10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
        end
        r_s2_mode   <= i_req.mode;
        r_s2_health <= i_req.health_mask;
        r_s2_fast   <= n_p100[smfg_pkg::DivShift +: 3];
        r_s2_slow   <= n_p500[smfg_pkg::DivShift];
        r_s2_tens   <= n_tens;
        r_s2_ones   <= n_ones[3:0];
    end

    // frame stage
    logic             r_s3_valid;
    smfg_pkg::t_frame r_s3_frame;
    smfg_pkg::t_frame n_frame;

    always_comb begin
        n_frame = '0;
        case (r_s2_mode)
            smfg_pkg::MODE_BOOT, smfg_pkg::MODE_UPLOADING: begin
                n_frame[r_s2_fast] = smfg_pkg::STATUS_DOT;
            end
            smfg_pkg::MODE_NORMAL: begin
                if (!r_s2_slow) begin
                    n_frame[0] = smfg_pkg::STATUS_DOT;
                end
                for (int i = 0; i < 5; i++) begin
                    if (r_s2_health[3'(i)]) begin
                        n_frame[3'(i + 2)] = smfg_pkg::STATUS_DOT;
                    end
                end
            end
            smfg_pkg::MODE_COUNTDOWN: begin
                if (!r_s2_slow) begin
                    n_frame[0] = smfg_pkg::STATUS_DOT;
                end
            end
            smfg_pkg::MODE_AP_READY: begin
                for (int i = 0; i < smfg_pkg::NumRows; i++) begin
                    n_frame[3'(i)] = smfg_pkg::STATUS_DOT;
                end
            end
            smfg_pkg::MODE_APPLYING: begin
                if (!r_s2_fast[0]) begin
                    for (int i = 0; i < smfg_pkg::NumRows; i++) begin
                        n_frame[3'(i)] = smfg_pkg::STATUS_DOT;
                    end
                end
            end
            smfg_pkg::MODE_ERROR: begin
                for (int i = 0; i < 5; i++) begin
                    // tens above nine stays blank
                    if (r_s2_tens <= 5'd9) begin
                        n_frame[3'(i + 1)][4:2] =
                            smfg_pkg::glyph_row(r_s2_tens[3:0], 3'(i));
                    end
                    n_frame[3'(i + 1)][9:7] = smfg_pkg::glyph_row(r_s2_ones, 3'(i));
                end
            end
            default: begin
                n_frame = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_frame <= n_frame;
    end

    assign o_valid = r_s3_valid;
    assign o_frame = r_s3_frame;

endmodule

FILE: rtl/core/status_matrix_frame_generator.sv
// Status matrix frame generator. A request is taken on a clock edge with start
// high and busy low; the 12x8 frame comes back as eight row words on o_strobe,
// one per cycle, rows 0 to 7, with o_last_row marking row 7. Row 0 follows the
// request through the request register, the phase and frame stages of the
// renderer and the row emitter, and the rows follow without gaps. busy stays
// high after each request, so requests are spaced by the time the row emitter
// needs to send one frame; a request taken as soon as busy falls streams
// straight on after the previous frame's last row. The receiver cannot
// stall: each row word is valid for exactly one cycle.
module status_matrix_frame_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_error_code,
    input  logic [4:0]  i_health_mask,
    input  logic [31:0] i_time_ms,
    output logic        o_strobe,
    output logic [2:0]  o_row_index,
    output logic [11:0] o_row_pixels,
    output logic        o_last_row
);

    logic       accept;
    logic [2:0] r_gap;

    assign busy   = (r_gap != 3'd0);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= 3'd7;
        end else if (r_gap != 3'd0) begin
            r_gap <= r_gap - 3'd1;
        end
    end

    // request register
    logic           r_s1_valid;
    smfg_pkg::t_req r_s1_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_req <= '{mode: i_mode, error_code: i_error_code,
                          health_mask: i_health_mask, time_ms: i_time_ms};
        end
    end

    logic             frame_valid;
    smfg_pkg::t_frame frame;

    smfg_render u_render (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_req   (r_s1_req),
        .o_valid (frame_valid),
        .o_frame (frame)
    );

    // row emitter
    logic             r_active;
    logic [2:0]       r_cnt;
    smfg_pkg::t_frame r_frame;
    logic             r_strobe;
    logic [2:0]       r_row_index;
    logic [11:0]      r_row_pixels;
    logic             r_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (frame_valid) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_active <= 1'b0;
                end
            end
        end
        if (frame_valid) begin
            r_frame <= frame;
        end
        r_row_index  <= r_cnt;
        r_row_pixels <= r_frame[r_cnt];
        r_last_row   <= (r_cnt == 3'd7);
    end

    assign o_strobe     = r_strobe;
    assign o_row_index  = r_row_index;
    assign o_row_pixels = r_row_pixels;
    assign o_last_row   = r_last_row;

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after a request was taken");

    a_first_row_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 (o_strobe && (o_row_index == 3'd0)))
        else $error("row 0 did not follow a request in time");

    a_rows_in_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_row) |=> (o_strobe && (o_row_index == $past(o_row_index) + 3'd1)))
        else $error("frame rows broken or out of order");

    a_last_row_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last_row == (o_row_index == 3'd7)))
        else $error("last row flag out of step with row index");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned FAST_TICK_MS = 100;
    localparam int unsigned SLOW_TICK_MS = 500;
    localparam int unsigned RANDOM_WORDS = 155;
    localparam int unsigned CALM_TAIL    = 30;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned QUIET_LIMIT  = 1000;

    typedef struct packed {
        logic [2:0]  row;
        logic [11:0] pixels;
        logic        last;
    } t_row_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [2:0]  i_mode        = '0;
    logic [7:0]  i_error_code  = '0;
    logic [4:0]  i_health_mask = '0;
    logic [31:0] i_time_ms     = '0;
    logic        o_strobe;
    logic [2:0]  o_row_index;
    logic [11:0] o_row_pixels;
    logic        o_last_row;

    smfg_pkg::t_req   render_jobs[$];
    t_row_word        pending_rows[$];
    smfg_pkg::t_req   offered;
    t_row_word        want;
    smfg_pkg::t_frame frame;
    int unsigned words_total   = 0;
    int unsigned words_offered = 0;
    int unsigned words_taken   = 0;
    int unsigned gap_left      = 0;
    int unsigned quiet_cycles  = 0;
    bit          launch;
    bit          mismatch_seen = 1'b0;

    status_matrix_frame_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_error_code  (i_error_code),
        .i_health_mask (i_health_mask),
        .i_time_ms     (i_time_ms),
        .o_strobe      (o_strobe),
        .o_row_index   (o_row_index),
        .o_row_pixels  (o_row_pixels),
        .o_last_row    (o_last_row)
    );

    always #5 i_clk = ~i_clk;

    // 3x5 font, five rows of three pixels, top row in the high bits, left pixel first
    function automatic logic [14:0] digit_glyph(input int unsigned d);
        case (d)
            0: return 15'b111_101_101_101_111;
            1: return 15'b010_110_010_010_111;
            2: return 15'b111_001_111_100_111;
            3: return 15'b111_001_111_001_111;
            4: return 15'b101_101_111_001_001;
            5: return 15'b111_100_111_001_111;
            6: return 15'b111_100_111_101_111;
            7: return 15'b111_001_001_001_001;
            8: return 15'b111_101_111_101_111;
            9: return 15'b111_101_111_001_111;
            default: return '0;
        endcase
    endfunction

    function automatic smfg_pkg::t_frame predict_frame(input smfg_pkg::t_req rq);
        smfg_pkg::t_frame f;
        int unsigned      t;
        int unsigned      tens;
        int unsigned      ones;
        logic [2:0]       g;
        logic [11:0]      strip;
        f = '0;
        t = rq.time_ms;
        case (rq.mode)
            smfg_pkg::MODE_BOOT, smfg_pkg::MODE_UPLOADING: begin
                f[3'((t / FAST_TICK_MS) % smfg_pkg::NumRows)] = smfg_pkg::STATUS_DOT;
            end
            smfg_pkg::MODE_NORMAL: begin
                if (((t / SLOW_TICK_MS) % 2) == 0) f[0] = smfg_pkg::STATUS_DOT;
                for (int r = 0; r < 5; r++) begin
                    if (rq.health_mask[r]) f[3'(2 + r)] = smfg_pkg::STATUS_DOT;
                end
            end
            smfg_pkg::MODE_COUNTDOWN: begin
                if (((t / SLOW_TICK_MS) % 2) == 0) f[0] = smfg_pkg::STATUS_DOT;
            end
            smfg_pkg::MODE_AP_READY: begin
                for (int r = 0; r < smfg_pkg::NumRows; r++) f[3'(r)] = smfg_pkg::STATUS_DOT;
            end
            smfg_pkg::MODE_APPLYING: begin
                if (((t / FAST_TICK_MS) % 2) == 0) begin
                    for (int r = 0; r < smfg_pkg::NumRows; r++) begin
                        f[3'(r)] = smfg_pkg::STATUS_DOT;
                    end
                end
            end
            smfg_pkg::MODE_ERROR: begin
                tens = rq.error_code / 10;
                ones = rq.error_code % 10;
                for (int r = 0; r < 5; r++) begin
                    // left glyph pixel lands on the lowest column of the digit
                    if (tens <= 9) begin
                        g = 3'(digit_glyph(tens) >> (3 * (4 - r)));
                        strip = {9'd0, g[0], g[1], g[2]};
                        f[3'(1 + r)] = f[3'(1 + r)] | (strip << 2);
                    end
                    g = 3'(digit_glyph(ones) >> (3 * (4 - r)));
                    strip = {9'd0, g[0], g[1], g[2]};
                    f[3'(1 + r)] = f[3'(1 + r)] | (strip << 7);
                end
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    task automatic add_word(input logic [2:0] mode, input logic [7:0] code,
                            input logic [4:0] health, input logic [31:0] t);
        smfg_pkg::t_req rq;
        rq.mode        = mode;
        rq.error_code  = code;
        rq.health_mask = health;
        rq.time_ms     = t;
        render_jobs.push_back(rq);
    endtask

    // driver: holds a word until taken, inserts random idle bursts, noise when idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                frame = predict_frame(offered);
                for (int r = 0; r < smfg_pkg::NumRows; r++) begin
                    want.row    = 3'(r);
                    want.pixels = frame[3'(r)];
                    want.last   = (r == smfg_pkg::NumRows - 1);
                    pending_rows.push_back(want);
                end
                words_taken++;
            end
            if (!(start && busy)) begin
                launch = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (render_jobs.size() != 0) begin
                    if (words_offered + CALM_TAIL < words_total
                        && ((words_offered / 32) % 2) == 0
                        && $urandom_range(0, 3) == 0) begin
                        gap_left = $urandom_range(0, 15);
                    end else begin
                        launch = 1'b1;
                    end
                end
                if (launch) begin
                    offered = render_jobs.pop_front();
                    words_offered++;
                    start         <= 1'b1;
                    i_mode        <= offered.mode;
                    i_error_code  <= offered.error_code;
                    i_health_mask <= offered.health_mask;
                    i_time_ms     <= offered.time_ms;
                end else begin
                    start <= 1'b0;
                    {i_mode, i_error_code, i_health_mask} <= 16'($urandom);
                    i_time_ms <= $urandom;
                end
            end
        end
    end

    // monitor: every strobed row word against the oldest predicted row
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row: expected none, actual row %0d pixels %h last %b",
                         $time, o_row_index, o_row_pixels, o_last_row);
                mismatch_seen = 1'b1;
            end else begin
                want = pending_rows.pop_front();
                if (o_strobe !== 1'b1) begin
                    $display("%0t: strobe expected 1, actual %b", $time, o_strobe);
                    mismatch_seen = 1'b1;
                end
                if (o_row_index !== want.row) begin
                    $display("%0t: row_index expected %0d, actual %0d",
                             $time, want.row, o_row_index);
                    mismatch_seen = 1'b1;
                end
                if (o_row_pixels !== want.pixels) begin
                    $display("%0t: row %0d row_pixels expected %h, actual %h",
                             $time, want.row, want.pixels, o_row_pixels);
                    mismatch_seen = 1'b1;
                end
                if (o_last_row !== want.last) begin
                    $display("%0t: row %0d last_row expected %b, actual %b",
                             $time, want.row, want.last, o_last_row);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: timeout, %0d of %0d words taken, %0d rows outstanding",
                         $time, words_taken, words_total, pending_rows.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0]  m;
        logic [31:0] t;
        // dot position, wrap and phase edges
        add_word(smfg_pkg::MODE_BOOT, 8'd0, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_BOOT, 8'd255, 5'd31, 32'd799);
        add_word(smfg_pkg::MODE_BOOT, 8'd0, 5'd0, 32'd800);
        add_word(smfg_pkg::MODE_UPLOADING, 8'd0, 5'd0, 32'hFFFF_FFFF);
        add_word(smfg_pkg::MODE_UPLOADING, 8'd17, 5'd3, 32'd350);
        add_word(smfg_pkg::MODE_NORMAL, 8'd0, 5'd31, 32'd0);
        add_word(smfg_pkg::MODE_NORMAL, 8'd0, 5'd0, 32'd500);
        add_word(smfg_pkg::MODE_NORMAL, 8'd0, 5'b10101, 32'd499);
        add_word(smfg_pkg::MODE_NORMAL, 8'd255, 5'b01010, 32'hFFFF_FFFF);
        add_word(smfg_pkg::MODE_COUNTDOWN, 8'd0, 5'd31, 32'd1000);
        add_word(smfg_pkg::MODE_COUNTDOWN, 8'd0, 5'd31, 32'd1500);
        add_word(smfg_pkg::MODE_AP_READY, 8'd0, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_APPLYING, 8'd0, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_APPLYING, 8'd0, 5'd0, 32'd100);
        add_word(smfg_pkg::MODE_APPLYING, 8'd0, 5'd0, 32'hFFFF_FFFF);
        // error digits, including a tens digit above nine
        add_word(smfg_pkg::MODE_ERROR, 8'd0, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_ERROR, 8'd9, 5'd31, 32'd123);
        add_word(smfg_pkg::MODE_ERROR, 8'd10, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_ERROR, 8'd99, 5'd0, 32'hFFFF_FFFF);
        add_word(smfg_pkg::MODE_ERROR, 8'd100, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_ERROR, 8'd109, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_ERROR, 8'd255, 5'd31, 32'd0);
        add_word(smfg_pkg::MODE_ERROR, 8'd87, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_ERROR, 8'd43, 5'd0, 32'd0);
        add_word(smfg_pkg::MODE_BLANK, 8'd255, 5'd31, 32'hFFFF_FFFF);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            m = ($urandom_range(0, 3) == 0) ? smfg_pkg::MODE_ERROR : 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0: t = $urandom_range(0, 5000);
                1: t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                default: t = $urandom;
            endcase
            add_word(m, 8'($urandom), 5'($urandom), t);
        end
        words_total = render_jobs.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (words_taken < words_total || pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!mismatch_seen) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
